// File: rtl/cpt_pkg.sv
// ----------------------------------------------------------------------------
// Closest point on triangle: shared package
// Widths, region codes and the side-band record shared by the top level,
// the pipelined divider and the port checker.
// ----------------------------------------------------------------------------
`default_nettype none

package cpt_pkg;

  // Coordinate format.
  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 8;

  // Derived widths.
  localparam int CW   = COORD_BITS;           // coordinate
  localparam int EW   = CW + 1;               // edge vector and negated vertex
  localparam int DW   = 2 * EW + 2;           // dot product
  localparam int HW   = DW / 2;               // split point of a dot product
  localparam int PPW  = 2 * HW + 2;           // partial product of a cross term
  localparam int XPW  = 2 * DW;               // full cross product
  localparam int XW   = XPW + 1;              // difference of two cross products
  localparam int TW   = DW + 1;               // difference of two dot products
  localparam int SW   = XW + 2;               // face denominator
  localparam int NMW  = XW + FRAC_BITS;       // numerator magnitude and quotient
  localparam int DMW  = SW;                   // denominator magnitude
  localparam int KC   = 3;                    // quotient chunks per multiply
  localparam int CHW  = (NMW + KC - 1) / KC;  // chunk width
  localparam int QPW  = KC * CHW;             // padded quotient
  localparam int MPW  = CHW + 1 + EW;         // chunk times edge
  localparam int PW   = QPW + EW + 1;         // quotient times edge
  localparam int SMW  = PW + 1;               // sum of two scaled edges

  // Cycles from the accepting edge to the edge that takes the result.
  localparam int LATENCY = NMW + 12;

  // Voronoi region of the result.
  typedef enum logic [2:0] {
    REG_A,
    REG_B,
    REG_AB,
    REG_C,
    REG_AC,
    REG_BC,
    REG_FACE,
    REG_DEGEN
  } region_e;

  // Data that rides along with an item through the divider.
  typedef struct packed {
    region_e               region;
    logic [2:0][CW-1:0]    base;
    logic [2:0][EW-1:0]    e0;
    logic [2:0][EW-1:0]    e1;
    logic                  neg0;
    logic                  neg1;
  } side_t;

endpackage

`default_nettype wire

// File: rtl/cpt_div.sv
// ----------------------------------------------------------------------------
// Closest point on triangle: pipelined two-lane divider
// Restoring division of two unsigned numerators by one shared denominator,
// one quotient bit per stage, with a side-band record carried alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module cpt_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  cpt_pkg::side_t             side_i,
  input  logic [cpt_pkg::NMW-1:0]    n0_i,
  input  logic [cpt_pkg::NMW-1:0]    n1_i,
  input  logic [cpt_pkg::DMW-1:0]    d_i,
  output logic                       valid_o,
  output cpt_pkg::side_t             side_o,
  output logic [cpt_pkg::NMW-1:0]    q0_o,
  output logic [cpt_pkg::NMW-1:0]    q1_o
);
  import cpt_pkg::*;

  logic             vld_q  [NMW];
  side_t            side_q [NMW];
  logic [DMW-1:0]   den_q  [NMW];
  logic [DMW-1:0]   rem_q  [NMW][2];
  logic [NMW-1:0]   nq_q   [NMW][2];

  for (genvar s = 0; s < NMW; s++) begin : g_stage
    logic             vld_src;
    side_t            side_src;
    logic [DMW-1:0]   den_src;
    logic [DMW-1:0]   rem_src [2];
    logic [NMW-1:0]   nq_src  [2];
    logic [DMW-1:0]   rem_d   [2];
    logic [NMW-1:0]   nq_d    [2];

    // The first stage takes the item from the ports.
    if (s == 0) begin : g_first
      assign vld_src    = valid_i;
      assign side_src   = side_i;
      assign den_src    = d_i;
      assign rem_src[0] = '0;
      assign rem_src[1] = '0;
      assign nq_src[0]  = n0_i;
      assign nq_src[1]  = n1_i;
    end else begin : g_next
      assign vld_src    = vld_q[s-1];
      assign side_src   = side_q[s-1];
      assign den_src    = den_q[s-1];
      assign rem_src[0] = rem_q[s-1][0];
      assign rem_src[1] = rem_q[s-1][1];
      assign nq_src[0]  = nq_q[s-1][0];
      assign nq_src[1]  = nq_q[s-1][1];
    end

    // One restoring step per lane: shift in the next numerator bit and
    // subtract the denominator when it fits.
    always_comb begin
      logic [DMW:0]   trial;
      logic [DMW+1:0] diff;
      for (int l = 0; l < 2; l++) begin
        trial = {rem_src[l], nq_src[l][NMW-1]};
        diff  = {1'b0, trial} - {2'b00, den_src};
        if (!diff[DMW+1]) begin
          rem_d[l] = diff[DMW-1:0];
          nq_d[l]  = {nq_src[l][NMW-2:0], 1'b1};
        end else begin
          rem_d[l] = trial[DMW-1:0];
          nq_d[l]  = {nq_src[l][NMW-2:0], 1'b0};
        end
      end
    end

    // Valid bit of the stage.
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_src;
      end
    end

    // Payload of the stage.
    always_ff @(posedge clk_i) begin
      side_q[s]   <= side_src;
      den_q[s]    <= den_src;
      rem_q[s][0] <= rem_d[0];
      rem_q[s][1] <= rem_d[1];
      nq_q[s][0]  <= nq_d[0];
      nq_q[s][1]  <= nq_d[1];
    end
  end

  assign valid_o = vld_q[NMW-1];
  assign side_o  = side_q[NMW-1];
  assign q0_o    = nq_q[NMW-1][0];
  assign q1_o    = nq_q[NMW-1][1];

endmodule

`default_nettype wire

// File: rtl/closest_point_on_triangle.sv
// ----------------------------------------------------------------------------
// Closest point on triangle
// Finds the point of a triangle nearest the origin, with its Voronoi region.
// ----------------------------------------------------------------------------
// Usage:
//   An item is three vertices on a_*_i, b_*_i and c_*_i. It is taken at a
//   rising edge where start is high and busy is low. busy stays low, so an
//   item can be given at every edge.
//   Each item gives one result on near_*_o and region_o, marked by done_o
//   for exactly one cycle. The result is taken at the edge that ends that
//   cycle; the receiver cannot hold it off.
//   Throughput is one item per cycle. Each item passes eight front stages
//   (dot products, cross products, region choice), then the restoring
//   divider, one quotient bit per stage over NMW = 81 bits, then four
//   back stages (scaled edge and saturation).
//   Results leave in the order the items came in.
//   Reset clears every valid bit at once; items in flight are dropped and
//   no result is strobed until a new item has gone through.
// ----------------------------------------------------------------------------
`default_nettype none

module closest_point_on_triangle (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [cpt_pkg::CW-1:0]   a_x_i,
  input  logic signed [cpt_pkg::CW-1:0]   a_y_i,
  input  logic signed [cpt_pkg::CW-1:0]   a_z_i,
  input  logic signed [cpt_pkg::CW-1:0]   b_x_i,
  input  logic signed [cpt_pkg::CW-1:0]   b_y_i,
  input  logic signed [cpt_pkg::CW-1:0]   b_z_i,
  input  logic signed [cpt_pkg::CW-1:0]   c_x_i,
  input  logic signed [cpt_pkg::CW-1:0]   c_y_i,
  input  logic signed [cpt_pkg::CW-1:0]   c_z_i,
  output logic                            done_o,
  output logic signed [cpt_pkg::CW-1:0]   near_x_o,
  output logic signed [cpt_pkg::CW-1:0]   near_y_o,
  output logic signed [cpt_pkg::CW-1:0]   near_z_o,
  output logic [2:0]                      region_o
);
  import cpt_pkg::*;

  // Vertices and edges that travel through the front stages.
  typedef struct packed {
    logic [2:0][CW-1:0] a;
    logic [2:0][CW-1:0] b;
    logic [2:0][CW-1:0] c;
    logic [2:0][EW-1:0] ab;
    logic [2:0][EW-1:0] ac;
    logic [2:0][EW-1:0] bc;
  } geo_t;

  // Operand pairs of the cross terms: d1*d4, d3*d2, d5*d2, d1*d6, d3*d6, d5*d4.
  localparam int PX [6] = '{0, 2, 4, 0, 2, 4};
  localparam int PY [6] = '{3, 1, 1, 5, 5, 3};

  localparam logic signed [SMW-1:0] CMAX = {{(SMW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [SMW-1:0] CMIN = {{(SMW-CW+1){1'b1}}, {(CW-1){1'b0}}};

  // The pipeline never stalls, so an item is taken at every edge.
  assign busy = 1'b0;

  // --------------------------------------------------------------------------
  // Valid bits of all stages outside the divider.
  // --------------------------------------------------------------------------
  logic v0_q, v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q;
  logic m1_v_q, m2_v_q, m3_v_q, done_q;
  logic div_v;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q   <= 1'b0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      v5_q   <= 1'b0;
      v6_q   <= 1'b0;
      v7_q   <= 1'b0;
      m1_v_q <= 1'b0;
      m2_v_q <= 1'b0;
      m3_v_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v0_q   <= start & ~busy;
      v1_q   <= v0_q;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      v4_q   <= v3_q;
      v5_q   <= v4_q;
      v6_q   <= v5_q;
      v7_q   <= v6_q;
      m1_v_q <= div_v;
      m2_v_q <= m1_v_q;
      m3_v_q <= m2_v_q;
      done_q <= m3_v_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: input register.
  // --------------------------------------------------------------------------
  logic signed [CW-1:0] a0_q [3];
  logic signed [CW-1:0] b0_q [3];
  logic signed [CW-1:0] c0_q [3];

  always_ff @(posedge clk_i) begin
    a0_q[0] <= a_x_i;
    a0_q[1] <= a_y_i;
    a0_q[2] <= a_z_i;
    b0_q[0] <= b_x_i;
    b0_q[1] <= b_y_i;
    b0_q[2] <= b_z_i;
    c0_q[0] <= c_x_i;
    c0_q[1] <= c_y_i;
    c0_q[2] <= c_z_i;
  end

  // --------------------------------------------------------------------------
  // Stage 1: edges and the component products of the six dot products.
  // --------------------------------------------------------------------------
  geo_t                   geo1_d, geo1_q;
  logic signed [2*EW-1:0] pr1_d [6][3];
  logic signed [2*EW-1:0] pr1_q [6][3];

  always_comb begin
    logic signed [EW-1:0] ab, ac, bc, na, nb, nc;
    for (int k = 0; k < 3; k++) begin
      ab = EW'(b0_q[k]) - EW'(a0_q[k]);
      ac = EW'(c0_q[k]) - EW'(a0_q[k]);
      bc = EW'(c0_q[k]) - EW'(b0_q[k]);
      na = -EW'(a0_q[k]);
      nb = -EW'(b0_q[k]);
      nc = -EW'(c0_q[k]);
      geo1_d.a[k]  = a0_q[k];
      geo1_d.b[k]  = b0_q[k];
      geo1_d.c[k]  = c0_q[k];
      geo1_d.ab[k] = ab;
      geo1_d.ac[k] = ac;
      geo1_d.bc[k] = bc;
      pr1_d[0][k]  = ab * na;
      pr1_d[1][k]  = ac * na;
      pr1_d[2][k]  = ab * nb;
      pr1_d[3][k]  = ac * nb;
      pr1_d[4][k]  = ab * nc;
      pr1_d[5][k]  = ac * nc;
    end
  end

  always_ff @(posedge clk_i) begin
    geo1_q <= geo1_d;
    pr1_q  <= pr1_d;
  end

  // --------------------------------------------------------------------------
  // Stage 2: dot products d1 to d6.
  // --------------------------------------------------------------------------
  geo_t                 geo2_q;
  logic signed [DW-1:0] d2_d [6];
  logic signed [DW-1:0] d2_q [6];

  always_comb begin
    for (int j = 0; j < 6; j++) begin
      d2_d[j] = DW'(pr1_q[j][0]) + DW'(pr1_q[j][1]) + DW'(pr1_q[j][2]);
    end
  end

  always_ff @(posedge clk_i) begin
    geo2_q <= geo1_q;
    d2_q   <= d2_d;
  end

  // --------------------------------------------------------------------------
  // Stage 3: partial products of the cross terms, edge-BC differences.
  // --------------------------------------------------------------------------
  geo_t                  geo3_q;
  logic signed [DW-1:0]  d3_q [6];
  logic signed [PPW-1:0] cp3_d [6][4];
  logic signed [PPW-1:0] cp3_q [6][4];
  logic signed [TW-1:0]  t13_d, t23_d, t13_q, t23_q;

  always_comb begin
    logic signed [HW-1:0] xh, yh;
    logic signed [HW:0]   xl, yl;
    for (int p = 0; p < 6; p++) begin
      xh = d2_q[PX[p]][DW-1:HW];
      yh = d2_q[PY[p]][DW-1:HW];
      xl = {1'b0, d2_q[PX[p]][HW-1:0]};
      yl = {1'b0, d2_q[PY[p]][HW-1:0]};
      cp3_d[p][0] = xh * yh;
      cp3_d[p][1] = xh * yl;
      cp3_d[p][2] = xl * yh;
      cp3_d[p][3] = xl * yl;
    end
    t13_d = TW'(d2_q[3]) - TW'(d2_q[2]);
    t23_d = TW'(d2_q[4]) - TW'(d2_q[5]);
  end

  always_ff @(posedge clk_i) begin
    geo3_q <= geo2_q;
    d3_q   <= d2_q;
    cp3_q  <= cp3_d;
    t13_q  <= t13_d;
    t23_q  <= t23_d;
  end

  // --------------------------------------------------------------------------
  // Stage 4: full cross products from their partial products.
  // --------------------------------------------------------------------------
  geo_t                  geo4_q;
  logic signed [DW-1:0]  d4_q [6];
  logic signed [TW-1:0]  t14_q, t24_q;
  logic signed [XPW-1:0] xp4_d [6];
  logic signed [XPW-1:0] xp4_q [6];

  always_comb begin
    for (int p = 0; p < 6; p++) begin
      xp4_d[p] = (XPW'(cp3_q[p][0]) <<< (2 * HW))
               + ((XPW'(cp3_q[p][1]) + XPW'(cp3_q[p][2])) <<< HW)
               + XPW'(cp3_q[p][3]);
    end
  end

  always_ff @(posedge clk_i) begin
    geo4_q <= geo3_q;
    d4_q   <= d3_q;
    t14_q  <= t13_q;
    t24_q  <= t23_q;
    xp4_q  <= xp4_d;
  end

  // --------------------------------------------------------------------------
  // Stage 5: barycentric numerators va, vb and vc.
  // --------------------------------------------------------------------------
  geo_t                 geo5_q;
  logic signed [DW-1:0] d5_q [6];
  logic signed [TW-1:0] t15_q, t25_q;
  logic signed [XW-1:0] va5_q, vb5_q, vc5_q;

  always_ff @(posedge clk_i) begin
    geo5_q <= geo4_q;
    d5_q   <= d4_q;
    t15_q  <= t14_q;
    t25_q  <= t24_q;
    vc5_q  <= XW'(xp4_q[0]) - XW'(xp4_q[1]);
    vb5_q  <= XW'(xp4_q[2]) - XW'(xp4_q[3]);
    va5_q  <= XW'(xp4_q[4]) - XW'(xp4_q[5]);
  end

  // --------------------------------------------------------------------------
  // Stage 6: region tests in order and choice of quotient operands.
  // --------------------------------------------------------------------------
  side_t                side6_d, side6_q;
  logic signed [XW-1:0] num06_d, num16_d, num06_q, num16_q;
  logic signed [SW-1:0] den6_d, den6_q;
  logic [2:0][CW-1:0]   a6_q;

  always_comb begin
    logic signed [DW-1:0] d1, d2, d3, d4, d5, d6;
    d1 = d5_q[0];
    d2 = d5_q[1];
    d3 = d5_q[2];
    d4 = d5_q[3];
    d5 = d5_q[4];
    d6 = d5_q[5];
    side6_d      = '0;
    side6_d.base = geo5_q.a;
    num06_d      = '0;
    num16_d      = '0;
    den6_d       = SW'(1);
    priority if (d1 <= 0 && d2 <= 0) begin
      side6_d.region = REG_A;
    end else if (d3 >= 0 && d4 <= d3) begin
      side6_d.region = REG_B;
      side6_d.base   = geo5_q.b;
    end else if (vc5_q <= 0 && d1 >= 0 && d3 <= 0) begin
      side6_d.region = REG_AB;
      side6_d.e0     = geo5_q.ab;
      num06_d        = XW'(d1);
      den6_d         = SW'(d1) - SW'(d3);
    end else if (d6 >= 0 && d5 <= d6) begin
      side6_d.region = REG_C;
      side6_d.base   = geo5_q.c;
    end else if (vb5_q <= 0 && d2 >= 0 && d6 <= 0) begin
      side6_d.region = REG_AC;
      side6_d.e0     = geo5_q.ac;
      num06_d        = XW'(d2);
      den6_d         = SW'(d2) - SW'(d6);
    end else if (va5_q <= 0 && t15_q >= 0 && t25_q >= 0) begin
      side6_d.region = REG_BC;
      side6_d.base   = geo5_q.b;
      side6_d.e0     = geo5_q.bc;
      num06_d        = XW'(t15_q);
      den6_d         = SW'(t15_q) + SW'(t25_q);
    end else begin
      side6_d.region = REG_FACE;
      side6_d.e0     = geo5_q.ab;
      side6_d.e1     = geo5_q.ac;
      num06_d        = vb5_q;
      num16_d        = vc5_q;
      den6_d         = SW'(va5_q) + SW'(vb5_q) + SW'(vc5_q);
    end
  end

  always_ff @(posedge clk_i) begin
    side6_q <= side6_d;
    num06_q <= num06_d;
    num16_q <= num16_d;
    den6_q  <= den6_d;
    a6_q    <= geo5_q.a;
  end

  // --------------------------------------------------------------------------
  // Stage 7: zero denominator check, signs and magnitudes for the divider.
  // --------------------------------------------------------------------------
  side_t          side7_d, side7_q;
  logic [NMW-1:0] n07_d, n17_d, n07_q, n17_q;
  logic [DMW-1:0] d7_d, d7_q;

  always_comb begin
    logic           quot;
    logic [XW-1:0]  m0, m1;
    quot = (side6_q.region == REG_AB) || (side6_q.region == REG_AC) ||
           (side6_q.region == REG_BC) || (side6_q.region == REG_FACE);
    m0 = num06_q[XW-1] ? XW'(-num06_q) : XW'(num06_q);
    m1 = num16_q[XW-1] ? XW'(-num16_q) : XW'(num16_q);
    side7_d      = side6_q;
    side7_d.neg0 = num06_q[XW-1] ^ den6_q[SW-1];
    side7_d.neg1 = num16_q[XW-1] ^ den6_q[SW-1];
    n07_d        = NMW'(m0) << FRAC_BITS;
    n17_d        = NMW'(m1) << FRAC_BITS;
    d7_d         = den6_q[SW-1] ? DMW'(-den6_q) : DMW'(den6_q);
    // A zero denominator gives vertex A with the degenerate code.
    if (quot && (den6_q == '0)) begin
      side7_d.region = REG_DEGEN;
      side7_d.base   = a6_q;
      side7_d.e0     = '0;
      side7_d.e1     = '0;
      n07_d          = '0;
      n17_d          = '0;
      d7_d           = DMW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    side7_q <= side7_d;
    n07_q   <= n07_d;
    n17_q   <= n17_d;
    d7_q    <= d7_d;
  end

  // --------------------------------------------------------------------------
  // Quotient magnitudes, one bit per stage.
  // --------------------------------------------------------------------------
  side_t          div_side;
  logic [NMW-1:0] div_q0, div_q1;

  cpt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v7_q),
    .side_i  (side7_q),
    .n0_i    (n07_q),
    .n1_i    (n17_q),
    .d_i     (d7_q),
    .valid_o (div_v),
    .side_o  (div_side),
    .q0_o    (div_q0),
    .q1_o    (div_q1)
  );

  // --------------------------------------------------------------------------
  // Back stage 1: chunk products of quotient magnitude and edge.
  // --------------------------------------------------------------------------
  side_t                 m1_side_q;
  logic signed [MPW-1:0] pp_d [2][3][KC];
  logic signed [MPW-1:0] pp_q [2][3][KC];

  always_comb begin
    logic [QPW-1:0] qp0, qp1;
    qp0 = QPW'(div_q0);
    qp1 = QPW'(div_q1);
    for (int k = 0; k < 3; k++) begin
      for (int c = 0; c < KC; c++) begin
        pp_d[0][k][c] = $signed({1'b0, qp0[c*CHW +: CHW]}) * $signed(div_side.e0[k]);
        pp_d[1][k][c] = $signed({1'b0, qp1[c*CHW +: CHW]}) * $signed(div_side.e1[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    m1_side_q <= div_side;
    pp_q      <= pp_d;
  end

  // --------------------------------------------------------------------------
  // Back stage 2: magnitude times edge for each term.
  // --------------------------------------------------------------------------
  side_t                m2_side_q;
  logic signed [PW-1:0] tm_d [2][3];
  logic signed [PW-1:0] tm_q [2][3];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      for (int k = 0; k < 3; k++) begin
        tm_d[l][k] = '0;
        for (int c = 0; c < KC; c++) begin
          tm_d[l][k] = tm_d[l][k] + (PW'(pp_q[l][k][c]) <<< (c * CHW));
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    m2_side_q <= m1_side_q;
    tm_q      <= tm_d;
  end

  // --------------------------------------------------------------------------
  // Back stage 3: apply the quotient signs and add the two terms.
  // --------------------------------------------------------------------------
  side_t                 m3_side_q;
  logic signed [SMW-1:0] s_d [3];
  logic signed [SMW-1:0] s_q [3];

  always_comb begin
    logic signed [SMW-1:0] t0, t1;
    for (int k = 0; k < 3; k++) begin
      t0 = SMW'(tm_q[0][k]);
      t1 = SMW'(tm_q[1][k]);
      s_d[k] = (m2_side_q.neg0 ? -t0 : t0) + (m2_side_q.neg1 ? -t1 : t1);
    end
  end

  always_ff @(posedge clk_i) begin
    m3_side_q <= m2_side_q;
    s_q       <= s_d;
  end

  // --------------------------------------------------------------------------
  // Back stage 4: floor shift, add the base vertex, saturate.
  // --------------------------------------------------------------------------
  logic signed [CW-1:0] near_d [3];
  logic signed [CW-1:0] near_q [3];
  region_e              region_q;

  always_comb begin
    logic signed [SMW-1:0] f;
    for (int k = 0; k < 3; k++) begin
      f = (s_q[k] >>> FRAC_BITS) + SMW'($signed(m3_side_q.base[k]));
      if (f > CMAX) begin
        near_d[k] = CMAX[CW-1:0];
      end else if (f < CMIN) begin
        near_d[k] = CMIN[CW-1:0];
      end else begin
        near_d[k] = f[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    near_q   <= near_d;
    region_q <= m3_side_q.region;
  end

  assign done_o   = done_q;
  assign near_x_o = near_q[0];
  assign near_y_o = near_q[1];
  assign near_z_o = near_q[2];
  assign region_o = region_q;

endmodule

`default_nettype wire

// File: rtl/cpt_checker.sv
// ----------------------------------------------------------------------------
// Closest point on triangle: port checker
// Checks latency and vertex results as seen on the top level's ports.
// ----------------------------------------------------------------------------
`default_nettype none

module cpt_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  input  logic                            busy,
  input  logic signed [cpt_pkg::CW-1:0]   a_x_i,
  input  logic signed [cpt_pkg::CW-1:0]   a_y_i,
  input  logic signed [cpt_pkg::CW-1:0]   a_z_i,
  input  logic signed [cpt_pkg::CW-1:0]   b_x_i,
  input  logic signed [cpt_pkg::CW-1:0]   b_y_i,
  input  logic signed [cpt_pkg::CW-1:0]   b_z_i,
  input  logic signed [cpt_pkg::CW-1:0]   c_x_i,
  input  logic signed [cpt_pkg::CW-1:0]   c_y_i,
  input  logic signed [cpt_pkg::CW-1:0]   c_z_i,
  input  logic                            done_o,
  input  logic signed [cpt_pkg::CW-1:0]   near_x_o,
  input  logic signed [cpt_pkg::CW-1:0]   near_y_o,
  input  logic signed [cpt_pkg::CW-1:0]   near_z_o,
  input  logic [2:0]                      region_o
);
  import cpt_pkg::*;

  // Every accepted item gives its result after the fixed latency.
  a_item_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LATENCY done_o)
    else $error("accepted item gave no result at the expected cycle");

  // No result appears without an item accepted at the matching cycle.
  a_done_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, LATENCY))
    else $error("result strobed without a matching item");

  // Vertex A and degenerate results give vertex A itself.
  a_vertex_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (region_o == REG_A || region_o == REG_DEGEN)) |->
      (near_x_o == $past(a_x_i, LATENCY) && near_y_o == $past(a_y_i, LATENCY) &&
       near_z_o == $past(a_z_i, LATENCY)))
    else $error("vertex A result differs from vertex A");

  // A vertex B result gives vertex B itself.
  a_vertex_b: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && region_o == REG_B) |->
      (near_x_o == $past(b_x_i, LATENCY) && near_y_o == $past(b_y_i, LATENCY) &&
       near_z_o == $past(b_z_i, LATENCY)))
    else $error("vertex B result differs from vertex B");

  // A vertex C result gives vertex C itself.
  a_vertex_c: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && region_o == REG_C) |->
      (near_x_o == $past(c_x_i, LATENCY) && near_y_o == $past(c_y_i, LATENCY) &&
       near_z_o == $past(c_z_i, LATENCY)))
    else $error("vertex C result differs from vertex C");

endmodule

bind closest_point_on_triangle cpt_checker u_cpt_checker (.*);

`default_nettype wire

// File: sim/closest_point_on_triangle_tb.sv
// ----------------------------------------------------------------------------
// Closest point on triangle: self-checking testbench
// Sends a short table of directed triangles, then random ones, with random
// gaps, and checks each result, point and region, against a wide-integer
// Voronoi region predictor; the first four rows carry their own answer.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module closest_point_on_triangle_tb;

  import cpt_pkg::*;

  localparam int N_RANDOM = 1650;
  localparam int MAX_REPORT = 10;

  // Wide enough for every intermediate of the region search.
  typedef logic signed [255:0] wide_t;
  typedef logic signed [CW-1:0] coord_t;

  typedef struct {
    coord_t  pt [3];
    region_e region;
  } near_t;

  typedef struct {
    coord_t  v [9];
    bit      typed;
    near_t   want;
  } row_t;

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   start = 1'b0;
  logic   busy;
  coord_t a_x_i = '0, a_y_i = '0, a_z_i = '0;
  coord_t b_x_i = '0, b_y_i = '0, b_z_i = '0;
  coord_t c_x_i = '0, c_y_i = '0, c_z_i = '0;
  logic   done_o;
  coord_t near_x_o, near_y_o, near_z_o;
  logic [2:0] region_o;

  near_t pending_points [$];
  int    mismatches = 0;
  int    items_sent = 0;
  int    region_hits [8];

  closest_point_on_triangle DUT (
    .clk_i, .rst_ni, .start, .busy,
    .a_x_i, .a_y_i, .a_z_i, .b_x_i, .b_y_i, .b_z_i, .c_x_i, .c_y_i, .c_z_i,
    .done_o, .near_x_o, .near_y_o, .near_z_o, .region_o
  );

  always #4 clk_i = ~clk_i;

  // Clamp a wide value to the coordinate range.
  function automatic coord_t clamp_coord(wide_t x);
    wide_t hi, lo;
    hi = (wide_t'(1) <<< (CW - 1)) - 1;
    lo = -(wide_t'(1) <<< (CW - 1));
    if (x > hi) x = hi;
    if (x < lo) x = lo;
    return x[CW-1:0];
  endfunction

  function automatic wide_t dot3(wide_t u [3], wide_t w [3]);
    return u[0] * w[0] + u[1] * w[1] + u[2] * w[2];
  endfunction

  // Vertex result with the given region.
  function automatic near_t vertex_point(wide_t p [3], region_e r);
    near_t res;
    for (int k = 0; k < 3; k++) res.pt[k] = clamp_coord(p[k]);
    res.region = r;
    return res;
  endfunction

  // Point on an edge: base plus floor(q * edge) in the coordinate format.
  function automatic near_t edge_point(wide_t p [3], wide_t e [3], wide_t q, region_e r);
    near_t res;
    for (int k = 0; k < 3; k++) res.pt[k] = clamp_coord(p[k] + ((q * e[k]) >>> FRAC_BITS));
    res.region = r;
    return res;
  endfunction

  // Predict the closest point of triangle ABC to the origin.
  function automatic near_t closest_point(coord_t v [9]);
    wide_t a [3], b [3], c [3], ab [3], ac [3], bc [3], na [3], nb [3], nc [3];
    wide_t d1, d2, d3, d4, d5, d6, va, vb, vc, den, t1, t2, qv, qw, s;
    wide_t scale;
    near_t res;
    scale = wide_t'(1) <<< FRAC_BITS;
    for (int k = 0; k < 3; k++) begin
      a[k] = wide_t'(v[k]);
      b[k] = wide_t'(v[3 + k]);
      c[k] = wide_t'(v[6 + k]);
      ab[k] = b[k] - a[k];
      ac[k] = c[k] - a[k];
      bc[k] = c[k] - b[k];
      na[k] = -a[k];
      nb[k] = -b[k];
      nc[k] = -c[k];
    end
    d1 = dot3(ab, na);
    d2 = dot3(ac, na);
    if (d1 <= 0 && d2 <= 0) return vertex_point(a, REG_A);
    d3 = dot3(ab, nb);
    d4 = dot3(ac, nb);
    if (d3 >= 0 && d4 <= d3) return vertex_point(b, REG_B);
    vc = d1 * d4 - d3 * d2;
    if (vc <= 0 && d1 >= 0 && d3 <= 0) begin
      den = d1 - d3;
      if (den == 0) return vertex_point(a, REG_DEGEN);
      return edge_point(a, ab, (d1 * scale) / den, REG_AB);
    end
    d5 = dot3(ab, nc);
    d6 = dot3(ac, nc);
    if (d6 >= 0 && d5 <= d6) return vertex_point(c, REG_C);
    vb = d5 * d2 - d1 * d6;
    if (vb <= 0 && d2 >= 0 && d6 <= 0) begin
      den = d2 - d6;
      if (den == 0) return vertex_point(a, REG_DEGEN);
      return edge_point(a, ac, (d2 * scale) / den, REG_AC);
    end
    va = d3 * d6 - d5 * d4;
    t1 = d4 - d3;
    t2 = d5 - d6;
    if (va <= 0 && t1 >= 0 && t2 >= 0) begin
      den = t1 + t2;
      if (den == 0) return vertex_point(a, REG_DEGEN);
      return edge_point(b, bc, (t1 * scale) / den, REG_BC);
    end
    // Face interior.
    den = va + vb + vc;
    if (den == 0) return vertex_point(a, REG_DEGEN);
    qv = (vb * scale) / den;
    qw = (vc * scale) / den;
    for (int k = 0; k < 3; k++) begin
      s = qv * ab[k] + qw * ac[k];
      res.pt[k] = clamp_coord(a[k] + (s >>> FRAC_BITS));
    end
    res.region = REG_FACE;
    return res;
  endfunction

  // Drive one item after a random gap and hold it until it is taken.
  task automatic send_triangle(coord_t v [9], bit typed, near_t want, int gap);
    near_t exp_pt;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    {a_x_i, a_y_i, a_z_i} <= {v[0], v[1], v[2]};
    {b_x_i, b_y_i, b_z_i} <= {v[3], v[4], v[5]};
    {c_x_i, c_y_i, c_z_i} <= {v[6], v[7], v[8]};
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    exp_pt = typed ? want : closest_point(v);
    pending_points = {pending_points, exp_pt};
    items_sent++;
  endtask

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(0, 4096) - 2048);
      default: return coord_t'($urandom_range(0, 64) - 32);
    endcase
  endfunction

  // Check each result against the oldest expectation.
  always @(posedge clk_i) begin
    near_t want;
    if (rst_ni && done_o) begin
      region_hits[region_o]++;
      if (pending_points.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORT)
          $display("unexpected result: (%0d, %0d, %0d) region %0d",
                   near_x_o, near_y_o, near_z_o, region_o);
      end else begin
        want = pending_points.pop_front();
        if (near_x_o !== want.pt[0] || near_y_o !== want.pt[1] ||
            near_z_o !== want.pt[2] || region_o !== want.region) begin
          mismatches++;
          if (mismatches <= MAX_REPORT)
            $display("mismatch: expected (%0d, %0d, %0d) region %0d, got (%0d, %0d, %0d) region %0d",
                     want.pt[0], want.pt[1], want.pt[2], want.region,
                     near_x_o, near_y_o, near_z_o, region_o);
        end
      end
    end
  end

  // Main sequence: directed table, random triangles, drain.
  initial begin
    row_t  rows [$];
    row_t  r;
    coord_t v [9];
    near_t none;
    int    mode, shape, quiet;
    none.pt = '{default: '0};
    none.region = REG_A;

    // Origin triangle, a point triangle and one with A nearest: vertex A.
    r.v = '{default: '0}; r.typed = 1; r.want = none; rows = {rows, r};
    r.v = '{256, 0, 0, 256, 0, 0, 256, 0, 0}; r.typed = 1;
    r.want.pt = '{256, 0, 0}; r.want.region = REG_A; rows = {rows, r};
    r.v = '{100, 0, 0, 1000, 0, 0, 100, 1000, 0}; r.typed = 1;
    r.want.pt = '{100, 0, 0}; r.want.region = REG_A; rows = {rows, r};
    // A equal to B with C on the far side: zero denominator.
    r.v = '{256, 0, 0, 256, 0, 0, -256, 0, 0}; r.typed = 1;
    r.want.pt = '{256, 0, 0}; r.want.region = REG_DEGEN; rows = {rows, r};
    r.typed = 0;
    // One row per region, plus extremes and collinear cases.
    r.v = '{1000, 0, 0, 100, 0, 0, 100, 900, 0}; rows = {rows, r};
    r.v = '{-512, 300, 0, 512, 300, 0, 0, 900, 0}; rows = {rows, r};
    r.v = '{1000, 1000, 0, 1000, 900, 0, 50, 50, 0}; rows = {rows, r};
    r.v = '{-512, 300, 0, 900, 900, 0, 512, 300, 0}; rows = {rows, r};
    r.v = '{900, 900, 0, -512, 300, 0, 512, 300, 0}; rows = {rows, r};
    r.v = '{-256, -256, 256, 256, -256, 256, 0, 256, 256}; rows = {rows, r};
    r.v = '{-32768, -32768, -32768, 32767, 32767, 32767, 32767, -32768, 32767};
    rows = {rows, r};
    r.v = '{32767, 32767, 32767, -32768, -32768, -32768, -32768, 32767, 32767};
    rows = {rows, r};
    r.v = '{-32768, 0, 0, 32767, 0, 0, 0, 32767, -32768}; rows = {rows, r};
    r.v = '{-32768, 100, 0, 32767, 100, 0, 0, 100, 0}; rows = {rows, r};
    r.v = '{-300, 50, 7, 600, 50, 7, 1500, 50, 7}; rows = {rows, r};
    r.v = '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767};
    rows = {rows, r};
    r.v = '{-32768, -32768, -32768, 32767, 32767, 32767, -32768, -32768, -32768};
    rows = {rows, r};
    r.v = '{5, -3, 1, -7, 2, 4, 3, 6, -5}; rows = {rows, r};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (rows[i]) send_triangle(rows[i].v, rows[i].typed, rows[i].want,
                                    $urandom_range(0, 10));

    // Random triangles: mostly small ones near the origin so that every
    // region is reached, some full-range, some with coincident vertices.
    quiet = 0;
    for (int n = 0; n < N_RANDOM; n++) begin
      mode = $urandom_range(0, 9);
      mode = (mode < 2) ? 0 : (mode < 7) ? 1 : 2;
      for (int k = 0; k < 9; k++) v[k] = rand_coord(mode);
      shape = $urandom_range(0, 9);
      if (shape == 0) for (int k = 0; k < 3; k++) v[3 + k] = v[k];
      if (shape == 1) for (int k = 0; k < 3; k++) v[6 + k] = v[k];
      if (shape == 2) for (int k = 0; k < 3; k++) v[6 + k] = v[3 + k];
      if (shape == 3) for (int k = 0; k < 3; k++) v[6 + k] = coord_t'(2 * v[3 + k] - v[k]);
      if (quiet == 0 && $urandom_range(0, 19) == 0) quiet = $urandom_range(10, 60);
      send_triangle(v, 0, none, (quiet > 0) ? 0 : $urandom_range(0, 10));
      if (quiet > 0) quiet--;
    end
    start <= 1'b0;

    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 20) @(posedge clk_i);

    $display("sent %0d triangles; regions A %0d B %0d AB %0d C %0d AC %0d BC %0d",
             items_sent, region_hits[0], region_hits[1], region_hits[2],
             region_hits[3], region_hits[4], region_hits[5]);
    $display("face %0d, degenerate %0d, mismatches %0d",
             region_hits[6], region_hits[7], mismatches);
    if (mismatches == 0 && pending_points.size() == 0) begin
      $display("closest_point_on_triangle regression: pass");
    end else begin
      $display("closest_point_on_triangle regression: fail");
    end
    $finish;
  end

  // Watchdog for a hung run.
  initial begin
    #2ms;
    $display("timeout with %0d results outstanding", pending_points.size());
    $display("closest_point_on_triangle regression: fail");
    $finish;
  end

endmodule

// File: closest_point_on_triangle.f
rtl/cpt_pkg.sv
rtl/cpt_div.sv
rtl/closest_point_on_triangle.sv
rtl/cpt_checker.sv
sim/closest_point_on_triangle_tb.sv
